// ===== design/tach_pkg.sv =====
// ----------------------------------------------------------------------------
// tach_pkg
// Shared types and constants of the period-based rpm tachometer.
// ----------------------------------------------------------------------------
package tach_pkg;

  // width of the timestamp arithmetic, wraps modulo 2^TimeBits
  localparam int unsigned TimeBits = 32;
  localparam int unsigned TimeInBits = 32;
  localparam int unsigned RpmBits = 16;
  localparam int unsigned TrigBits = 8;
  localparam int unsigned ProdBits = RpmBits + TrigBits;

  localparam logic [RpmBits-1:0] RpmNum = RpmBits'(60000);
  localparam logic [TrigBits-1:0] TrigReset = TrigBits'(6);

  // configuration port
  localparam int unsigned PaddrBits = 2;
  localparam int unsigned PdataBits = 32;
  localparam int unsigned RegTriggersPerRev = 0;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [RpmBits-1:0] rpm_t;
  typedef logic [TrigBits-1:0] trig_t;

  // request into the rpm calculator
  typedef struct packed {
    logic  start;
    time_t diff;
    trig_t trig;
  } calc_req_t;

  // answer from the rpm calculator
  typedef struct packed {
    logic done;
    rpm_t rpm;
  } calc_rsp_t;

endpackage

// ===== design/tach_if.sv =====
// ----------------------------------------------------------------------------
// tach_in_if / tach_out_if
// Valid/ready channels for sensor samples and rpm results.
// ----------------------------------------------------------------------------
interface tach_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  sensor_level;
  logic [tach_pkg::TimeInBits-1:0]       time_ms;

  modport source (output valid, output sensor_level, output time_ms, input ready);
  modport sink (input valid, input sensor_level, input time_ms, output ready);
endinterface

interface tach_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [tach_pkg::RpmBits-1:0]          rpm;
  logic                                  new_value;

  modport source (output valid, output rpm, output new_value, input ready);
  modport sink (input valid, input rpm, input new_value, output ready);
endinterface

// ===== design/tach_rpm_calc.sv =====
// ----------------------------------------------------------------------------
// tach_rpm_calc
// Bit-serial rpm calculator: shift-add multiply of period by triggers,
// then restoring division of 60000 by the product, one bit per cycle.
// ----------------------------------------------------------------------------
module tach_rpm_calc (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tach_pkg::calc_req_t req_i,
  output tach_pkg::calc_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV
  } state_e;

  localparam int unsigned RpmBits = tach_pkg::RpmBits;
  localparam int unsigned ProdBits = tach_pkg::ProdBits;

  state_e                  state_q;
  logic [3:0]              cnt_q;
  logic [ProdBits-1:0]     mcand_q;
  logic [ProdBits-1:0]     prod_q;
  tach_pkg::trig_t         mplier_q;
  logic [RpmBits:0]        rem_q;
  logic [RpmBits-1:0]      quo_q;
  logic                    done_q;
  tach_pkg::rpm_t          rpm_q;

  logic [RpmBits:0]        trial;
  logic [RpmBits:0]        shifted;

  assign shifted = {rem_q[RpmBits-1:0], quo_q[RpmBits-1]};
  assign trial   = shifted - {1'b0, prod_q[RpmBits-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      rpm_q    <= '0;
      mcand_q  <= '0;
      prod_q   <= '0;
      mplier_q <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (req_i.start) begin
            if (req_i.diff == '0 || req_i.trig == '0) begin
              rpm_q  <= tach_pkg::RpmNum;
              done_q <= 1'b1;
            end else if (req_i.diff > tach_pkg::TimeBits'(tach_pkg::RpmNum)) begin
              rpm_q  <= '0;
              done_q <= 1'b1;
            end else begin
              mcand_q  <= ProdBits'(req_i.diff[RpmBits-1:0]);
              mplier_q <= req_i.trig;
              prod_q   <= '0;
              cnt_q    <= 4'(tach_pkg::TrigBits - 1);
              state_q  <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mplier_q[0]) begin
            prod_q <= prod_q + mcand_q;
          end
          mcand_q  <= {mcand_q[ProdBits-2:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[tach_pkg::TrigBits-1:1]};
          cnt_q    <= cnt_q - 4'd1;
          if (cnt_q == '0) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (prod_q > ProdBits'(tach_pkg::RpmNum)) begin
            rpm_q   <= '0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            rem_q   <= '0;
            quo_q   <= tach_pkg::RpmNum;
            cnt_q   <= 4'(RpmBits - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          // keep the trial remainder when it did not go negative
          if (!trial[RpmBits]) begin
            rem_q <= trial;
          end else begin
            rem_q <= shifted;
          end
          quo_q <= {quo_q[RpmBits-2:0], ~trial[RpmBits]};
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == '0) begin
            rpm_q   <= {quo_q[RpmBits-2:0], ~trial[RpmBits]};
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rpm  = rpm_q;

endmodule

// ===== design/tachometer_rpm_measure_unit.sv =====
// ----------------------------------------------------------------------------
// tachometer_rpm_measure_unit
// Period-based rpm tachometer with an APB-style configuration port.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one sensor sample per beat (sensor_level, time_ms); out_if
//   returns exactly one beat per sample with the latest rpm and new_value.
//   A low level while armed is a falling edge: the period since the last
//   edge is multiplied by triggers_per_rev bit-serially and 60000 is
//   divided by the product one quotient bit per cycle. The multiply and
//   divide are skipped when the period is zero or above 60000 or
//   triggers_per_rev is zero, and the divide alone when only the product
//   exceeds 60000. An edge sample starts the calculator when accepted and
//   its result beat is registered from the calculator's done strobe; a
//   non-edge sample gives its result in the cycle after acceptance.
//   One sample is in work at a time; the next is taken while the previous
//   result still waits in the output register, as long as it leaves then.
//   If the receiver stalls, the result holds and in_if.ready drops.
//   Reset arms the edge detector, clears the last edge time and rpm and
//   sets triggers_per_rev to 6. Register triggers_per_rev sits at byte
//   address 0; write it only while the block is idle.
// ----------------------------------------------------------------------------
module tachometer_rpm_measure_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  tach_in_if.sink                            in_if,
  tach_out_if.source                         out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tach_pkg::PaddrBits-1:0]     paddr,
  input  logic [tach_pkg::PdataBits-1:0]     pwdata,
  output logic [tach_pkg::PdataBits-1:0]     prdata,
  output logic                               pready
);

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_e;

  state_e              state_q;
  logic                edge_seen_q;
  tach_pkg::time_t     last_edge_q;
  tach_pkg::rpm_t      last_rpm_q;
  tach_pkg::trig_t     trig_q;
  logic                out_valid_q;
  tach_pkg::rpm_t      out_rpm_q;
  logic                out_new_q;

  tach_pkg::time_t     now;
  logic                in_fire;
  logic                is_edge;
  logic                cfg_wr;
  tach_pkg::calc_req_t req;
  tach_pkg::calc_rsp_t rsp;

  assign now     = tach_pkg::TimeBits'(in_if.time_ms);
  assign in_if.ready = (state_q == ST_IDLE) && (!out_valid_q || out_if.ready);
  assign in_fire = in_if.valid && in_if.ready;
  assign is_edge = !in_if.sensor_level && !edge_seen_q;

  assign req.start = in_fire && is_edge;
  assign req.diff  = now - last_edge_q;
  assign req.trig  = trig_q;

  tach_rpm_calc u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr == tach_pkg::PaddrBits'(4 * tach_pkg::RegTriggersPerRev));
  assign prdata = tach_pkg::PdataBits'(trig_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q <= tach_pkg::TrigReset;
    end else if (cfg_wr) begin
      trig_q <= pwdata[tach_pkg::TrigBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      edge_seen_q <= 1'b0;
      last_edge_q <= '0;
      last_rpm_q  <= '0;
      out_valid_q <= 1'b0;
      out_rpm_q   <= '0;
      out_new_q   <= 1'b0;
    end else begin
      // drop the result beat once taken
      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            if (is_edge) begin
              edge_seen_q <= 1'b1;
              last_edge_q <= now;
              state_q     <= ST_CALC;
            end else begin
              if (in_if.sensor_level) begin
                edge_seen_q <= 1'b0;
              end
              out_valid_q <= 1'b1;
              out_rpm_q   <= last_rpm_q;
              out_new_q   <= 1'b0;
            end
          end
        end
        ST_CALC: begin
          if (rsp.done) begin
            last_rpm_q  <= rsp.rpm;
            out_valid_q <= 1'b1;
            out_rpm_q   <= rsp.rpm;
            out_new_q   <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.rpm       = out_rpm_q;
  assign out_if.new_value = out_new_q;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the period-based rpm tachometer. A driver and a
// monitor on the sample and result channels, an APB writer for
// triggers_per_rev, and an in-bench predictor that tracks the edge detector,
// the last edge stamp and the last rpm. Directed edge cases go first, then
// random pulse trains under several trigger counts with random stalls on
// both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam logic LevelLow = 1'b0;
  localparam logic LevelHigh = 1'b1;
  localparam logic [tach_pkg::PaddrBits-1:0] TrigAddr =
    tach_pkg::PaddrBits'(4 * tach_pkg::RegTriggersPerRev);
  localparam int unsigned RpmFull = 60000;
  localparam int SettleCycles = 32;
  localparam int QuietLimit = 4000;
  localparam int HoldOffCycles = 400;

  typedef struct packed {
    logic            level;
    tach_pkg::time_t stamp;
  } sample_t;

  typedef struct packed {
    tach_pkg::rpm_t rpm;
    logic           new_value;
  } reading_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [tach_pkg::PaddrBits-1:0] paddr;
  logic [tach_pkg::PdataBits-1:0] pwdata;
  logic [tach_pkg::PdataBits-1:0] prdata;
  logic pready;

  tach_in_if in_ch ();
  tach_out_if out_ch ();

  tachometer_rpm_measure_unit uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  tach_pkg::trig_t trig_cfg = tach_pkg::TrigReset;
  logic edge_held = 1'b0;
  tach_pkg::time_t last_stamp = '0;
  tach_pkg::rpm_t last_rpm = '0;

  sample_t samples_waiting[$];
  reading_t rpm_due[$];
  sample_t next_sample;
  reading_t want;
  bit in_took = 0;
  int errors = 0;
  int idle_pct = 28;
  int choke_reqs = 0;
  int choke_done = 0;
  int hold_left = 0;
  tach_pkg::time_t gen_edge = '0;

  always #6 clk = ~clk;

  function automatic tach_pkg::rpm_t period_to_rpm(tach_pkg::time_t span,
                                                   tach_pkg::trig_t trig);
    int unsigned prod;
    if (span == 0 || trig == 0) begin
      return tach_pkg::rpm_t'(RpmFull);
    end
    if (span > RpmFull) begin
      return '0;
    end
    prod = span * trig;
    if (prod > RpmFull) begin
      return '0;
    end
    return tach_pkg::rpm_t'(RpmFull / prod);
  endfunction

  function automatic reading_t advance_tach(logic level, tach_pkg::time_t stamp);
    reading_t r;
    r.new_value = 1'b0;
    if (level == LevelLow && !edge_held) begin
      edge_held = 1'b1;
      last_rpm = period_to_rpm(stamp - last_stamp, trig_cfg);
      last_stamp = stamp;
      r.new_value = 1'b1;
    end else if (level == LevelHigh) begin
      edge_held = 1'b0;
    end
    r.rpm = last_rpm;
    return r;
  endfunction

  // sample driver: hold the beat until taken, then advance
  always @(negedge clk) begin
    if (!in_ch.valid || in_took) begin
      if (samples_waiting.size() > 0 && $urandom_range(99) >= idle_pct) begin
        next_sample = samples_waiting.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.sensor_level <= next_sample.level;
        in_ch.time_ms <= next_sample.stamp;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (choke_done != choke_reqs) begin
      choke_done = choke_reqs;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // monitor: predict on each sample beat, check each result beat
  always @(posedge clk) begin
    in_took = in_ch.valid && in_ch.ready;
    if (rst_n && in_took) begin
      rpm_due.push_back(advance_tach(in_ch.sensor_level, in_ch.time_ms));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rpm_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got rpm %0d new_value %0b",
                 $time, out_ch.rpm, out_ch.new_value);
      end else begin
        want = rpm_due.pop_front();
        if (out_ch.rpm !== want.rpm) begin
          errors++;
          $display("%0t: rpm expected %0d, got %0d", $time, want.rpm, out_ch.rpm);
        end
        if (out_ch.new_value !== want.new_value) begin
          errors++;
          $display("%0t: new_value expected %0b, got %0b",
                   $time, want.new_value, out_ch.new_value);
        end
      end
    end
  end

  // watchdog on cycles with no beat and no register access
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb NOT OK");
    $finish;
  end

  task automatic feed(logic level, tach_pkg::time_t stamp);
    samples_waiting.push_back('{level: level, stamp: stamp});
  endtask

  // re-arm, then drop low at the given stamp
  task automatic pulse_at(tach_pkg::time_t stamp);
    feed(LevelHigh, stamp);
    feed(LevelLow, stamp);
    gen_edge = stamp;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (samples_waiting.size() > 0 || in_ch.valid || rpm_due.size() > 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_trig(tach_pkg::trig_t value);
    settle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TrigAddr;
    pwdata <= tach_pkg::PdataBits'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata[tach_pkg::TrigBits-1:0] !== value) begin
      errors++;
      $display("%0t: triggers_per_rev readback expected %0d, got %0d",
               $time, value, prdata[tach_pkg::TrigBits-1:0]);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    trig_cfg = value;
  endtask

  function automatic tach_pkg::time_t pick_span();
    int unsigned cap;
    int pick;
    cap = (trig_cfg == 0) ? RpmFull : RpmFull / trig_cfg;
    pick = $urandom_range(99);
    if (pick < 55) return tach_pkg::time_t'($urandom_range(1, cap));
    if (pick < 65) return '0;
    if (pick < 75) return tach_pkg::time_t'(cap + $urandom_range(0, 1));
    if (pick < 88) return tach_pkg::time_t'($urandom_range(cap + 1, 70000));
    return tach_pkg::time_t'($urandom);
  endfunction

  // mostly clean pulse trains with random periods, some stray samples
  task automatic gen_phase(int count);
    int made;
    int highs;
    int lows;
    tach_pkg::time_t span;
    tach_pkg::time_t at;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 80) begin
        span = pick_span();
        at = gen_edge + span;
        highs = $urandom_range(1, 3);
        lows = $urandom_range(1, 3);
        repeat (highs) begin
          feed(LevelHigh, gen_edge + tach_pkg::time_t'($urandom_range(0, span)));
        end
        feed(LevelLow, at);
        repeat (lows - 1) feed(LevelLow, at + tach_pkg::time_t'($urandom_range(0, 3)));
        gen_edge = at;
        made += highs + lows;
      end else begin
        feed(logic'($urandom_range(1)),
             ($urandom_range(1) != 0) ? gen_edge + tach_pkg::time_t'($urandom_range(0, 50))
                                      : tach_pkg::time_t'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sensor_level = LevelHigh;
    in_ch.time_ms = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // first edge measures from zero, then a low while disarmed
    feed(LevelHigh, 5);
    feed(LevelLow, 10);
    feed(LevelLow, 20);
    pulse_at(25);
    pulse_at(25);                // zero period saturates
    pulse_at(32'hFFFF_FFFF);     // huge period gives zero
    pulse_at(3);                 // period across the wrap
    pulse_at(10003);             // product exactly at the numerator
    pulse_at(20004);             // product just above it
    pulse_at(80005);             // period alone too long
    pulse_at(80006);
    feed(LevelHigh, 80010);
    feed(LevelHigh, 80011);

    set_trig(1);
    pulse_at(gen_edge + 1);
    pulse_at(gen_edge + 60000);
    pulse_at(gen_edge + 60001);
    set_trig(255);
    pulse_at(gen_edge + 1);
    pulse_at(gen_edge + 235);
    pulse_at(gen_edge + 236);
    set_trig(0);
    pulse_at(gen_edge + 5);
    pulse_at(gen_edge);

    set_trig(tach_pkg::trig_t'($urandom_range(2, 254)));
    gen_phase(182);
    set_trig(1);
    idle_pct = 0;
    gen_phase(182);
    set_trig(255);
    idle_pct = 28;
    gen_phase(182);
    choke_reqs++;
    set_trig(tach_pkg::trig_t'($urandom_range(1, 12)));
    gen_phase(182);
    set_trig(tach_pkg::TrigReset);
    gen_phase(182);
    settle();

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tach_pkg.sv
design/tach_if.sv
design/tach_rpm_calc.sv
design/tachometer_rpm_measure_unit.sv
sim/tb.sv
